// ----- rtl/rs_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, item codes and interface structs for the reservoir sampler
package rs_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int SIZE_W      = 11;
    localparam int VALUE_W     = 64;
    localparam int SEEN_W      = 32;
    localparam int RIDX_W      = 10;
    localparam int DIV_W       = SEEN_W + 1;
    localparam int STEP_W      = $clog2(SEEN_W);

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    typedef struct packed {
        logic               start;
        logic [SEEN_W-1:0]  dividend;
        logic [DIV_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_W-1:0]   rem;
    } t_div_rsp;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } t_mem_req;

endpackage

// ----- rtl/rs_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, returns the remainder
module rs_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rs_pkg::t_div_req i_req,
    output rs_pkg::t_div_rsp o_rsp
);
    import rs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_rem;
    logic [SEEN_W-1:0] r_dvd;
    logic [DIV_W-1:0]  r_dvs;

    logic [DIV_W:0]    trial;
    logic              fits;

    // remainder stays below the divisor, so one extra bit holds the shifted value
    assign trial = {r_rem, r_dvd[SEEN_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SEEN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_W'(trial - {1'b0, r_dvs}) : trial[DIV_W-1:0];
            r_dvd <= {r_dvd[SEEN_W-2:0], 1'b0};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- rtl/rs_mem.sv -----
`timescale 1ns / 1ps
// sample store: one write port and one registered read port
module rs_mem (
    input  logic                       i_clk,
    input  rs_pkg::t_mem_req           i_req,
    output logic [rs_pkg::VALUE_W-1:0] o_rdata
);
    import rs_pkg::*;

    logic [VALUE_W-1:0] r_mem [MAX_SAMPLES];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/reservoir_sampler.sv -----
`timescale 1ns / 1ps
// Reservoir sampler (Algorithm R) keeping up to min(sample_size, 1024) 64-bit values
// from a stream. One item is in work at a time and the input is stalled meanwhile. An
// add that replaces (seen count at or above the size) waits in S_DIV for the 32-step
// restoring divider that forms random_word mod (seen+1); a filling add, a read, a clear
// or an ignored item goes straight to S_FIN. The result sits in an
// output register, so the next item is taken while a result waits; the sequencer only
// holds when it finishes an item and the previous result has not been transferred.
// sample_size is written through the configuration port while the block is idle.
module reservoir_sampler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rs_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_kind,
    input  logic [rs_pkg::VALUE_W-1:0]  i_sample_value,
    input  logic                        i_has_value,
    input  logic [rs_pkg::SEEN_W-1:0]   i_random_word,
    input  logic [rs_pkg::RIDX_W-1:0]   i_read_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rs_pkg::VALUE_W-1:0]  o_slot_value,
    output logic                        o_slot_valid,
    output logic [rs_pkg::SIZE_W-1:0]   o_held_count,
    output logic [rs_pkg::SEEN_W-1:0]   o_seen_total
);
    import rs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_size;
    logic [SEEN_W-1:0]  r_seen, n_seen;
    logic [1:0]         r_kind;
    logic [RIDX_W-1:0]  r_ridx;
    logic [VALUE_W-1:0] r_value;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_slot_value, n_slot_value;
    logic               r_slot_valid, n_slot_valid;
    logic [SIZE_W-1:0]  r_held, n_held;
    logic [SEEN_W-1:0]  r_seen_out, n_seen_out;

    logic [SIZE_W-1:0]  eff_size;
    logic [SIZE_W-1:0]  held_now;
    logic [SEEN_W-1:0]  seen_inc;
    logic               filling;
    logic               accept;
    logic               out_free;
    logic               hit;
    logic [VALUE_W-1:0] rdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    t_mem_req           mem_req;

    assign eff_size = (r_size > SIZE_W'(MAX_SAMPLES)) ? SIZE_W'(MAX_SAMPLES) : r_size;
    assign filling  = r_seen < SEEN_W'(eff_size);
    assign held_now = filling ? r_seen[SIZE_W-1:0] : eff_size;
    assign seen_inc = (r_seen == '1) ? r_seen : r_seen + 1'b1;
    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign hit      = div_rsp.rem < DIV_W'(eff_size);

    assign o_in_stall  = r_state != S_IDLE;
    assign o_cfg_ready = r_state == S_IDLE;

    always_comb begin
        div_req.start    = accept && i_kind == KIND_ADD && i_has_value && !filling;
        div_req.dividend = i_random_word;
        div_req.divisor  = {1'b0, r_seen} + DIV_W'(1);

        mem_req.re    = accept && i_kind == KIND_READ;
        mem_req.raddr = i_read_index;
        if (r_state == S_DIV) begin
            mem_req.we    = div_rsp.done && hit;
            mem_req.waddr = div_rsp.rem[ADDR_W-1:0];
            mem_req.wdata = r_value;
        end else begin
            mem_req.we    = accept && i_kind == KIND_ADD && i_has_value && filling;
            mem_req.waddr = r_seen[ADDR_W-1:0];
            mem_req.wdata = i_sample_value;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_seen       = r_seen;
        n_out_valid  = r_out_valid && i_out_stall;
        n_slot_value = r_slot_value;
        n_slot_valid = r_slot_valid;
        n_held       = r_held;
        n_seen_out   = r_seen_out;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_FIN;
                    case (i_kind)
                        KIND_ADD: begin
                            if (i_has_value) begin
                                if (filling) begin
                                    n_seen = seen_inc;
                                end else begin
                                    n_state = S_DIV;
                                end
                            end
                        end
                        KIND_CLEAR: n_seen = '0;
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_seen  = seen_inc;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_slot_valid = r_kind == KIND_READ && SIZE_W'(r_ridx) < held_now;
                    n_slot_value = n_slot_valid ? rdata : '0;
                    n_held       = held_now;
                    n_seen_out   = r_seen;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
        end
        r_slot_value <= n_slot_value;
        r_slot_valid <= n_slot_valid;
        r_held       <= n_held;
        r_seen_out   <= n_seen_out;
        if (accept) begin
            r_kind  <= i_kind;
            r_ridx  <= i_read_index;
            r_value <= i_sample_value;
        end
    end

    rs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rs_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_slot_value = r_slot_value;
    assign o_slot_valid = r_slot_valid;
    assign o_held_count = r_held;
    assign o_seen_total = r_seen_out;

`ifndef ASSERT_OFF
    // the held count never runs past the seen count or the store depth
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (SEEN_W'(o_held_count) <= o_seen_total) &&
                        (o_held_count <= SIZE_W'(MAX_SAMPLES)))
        else $error("held count out of bounds");

    // a valid slot implies something is held
    a_slot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_valid |-> o_held_count != '0)
        else $error("valid slot with empty reservoir");

    // divider completion only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide wait");

    // a division is started only when the divider is free
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy && !div_rsp.done)
        else $error("divider restarted while busy");
`endif

endmodule
